// File: sv/tcc_pkg.sv
// Shared types and constants for the text console cursor/scroll engine.
// No dependencies; imported by the top level and by the testbench.
`default_nettype none

package tcc_pkg;

  // Request modes
  localparam logic [1:0] MODE_PUT   = 2'd0;
  localparam logic [1:0] MODE_CLEAR = 2'd1;
  localparam logic [1:0] MODE_ERASE = 2'd2;
  localparam logic [1:0] MODE_READ  = 2'd3;

  // Character codes
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Echo for a screen clear: ESC [ 2 J ESC [ H
  localparam int unsigned CLEAR_LEN = 7;
  localparam logic [7:0] CLEAR_SEQ [CLEAR_LEN] =
    '{8'h1B, 8'h5B, 8'h32, 8'h4A, 8'h1B, 8'h5B, 8'h48};

  typedef logic [$clog2(CLEAR_LEN)-1:0] seq_idx_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCROLL,
    ST_BLANK,
    ST_PUT,
    ST_ERASE,
    ST_CLEAR,
    ST_READ,
    ST_EMIT
  } state_e;

  // Which result sequence a request produces
  typedef enum logic [2:0] {
    SEQ_NEWLINE,
    SEQ_CHAR,
    SEQ_CLEAR,
    SEQ_ERASE,
    SEQ_READ
  } seq_e;

  // Echo byte at position idx of a sequence
  function automatic logic [7:0] seq_byte(seq_e s, seq_idx_t idx, logic [7:0] ch);
    logic [7:0] b;
    b = 8'h00;
    case (s)
      SEQ_NEWLINE: b = (idx == seq_idx_t'(0)) ? CH_CR : CH_LF;
      SEQ_CHAR:    b = ch;
      SEQ_CLEAR:   b = CLEAR_SEQ[idx];
      SEQ_ERASE:   b = (idx == seq_idx_t'(1)) ? CH_SPACE : CH_BS;
      SEQ_READ:    b = 8'h00;
      default:     b = 8'h00;
    endcase
    return b;
  endfunction

  // Index of the final result of a sequence
  function automatic seq_idx_t seq_last(seq_e s);
    seq_idx_t n;
    n = '0;
    case (s)
      SEQ_NEWLINE: n = seq_idx_t'(1);
      SEQ_CHAR:    n = seq_idx_t'(0);
      SEQ_CLEAR:   n = seq_idx_t'(CLEAR_LEN - 1);
      SEQ_ERASE:   n = seq_idx_t'(2);
      SEQ_READ:    n = seq_idx_t'(0);
      default:     n = seq_idx_t'(0);
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

// File: sv/tcc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tcc_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: sv/tcc_addr_unit.sv
// Shared cell address adder: row*COLUMNS+col for cursor accesses,
// or base+offset for the scroll sweep. Depends on nothing outside itself.
`default_nettype none

module tcc_addr_unit #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  wire logic                                  use_cursor_i,
  input  wire logic [$clog2(ROWS)-1:0]               row_i,
  input  wire logic [$clog2(COLUMNS+1)-1:0]          col_i,
  input  wire logic [$clog2(ROWS*COLUMNS)-1:0]       base_i,
  input  wire logic [$clog2(ROWS*COLUMNS)-1:0]       offset_i,
  output logic      [$clog2(ROWS*COLUMNS)-1:0]       sum_o
);

  localparam int unsigned AW = $clog2(ROWS * COLUMNS);

  logic [AW-1:0] row_base;
  logic [AW-1:0] op_a;
  logic [AW-1:0] op_b;

  // Constant multiply for the row start
  assign row_base = AW'(row_i) * AW'(COLUMNS);

  // Pick operands and add
  assign op_a  = use_cursor_i ? row_base : base_i;
  assign op_b  = use_cursor_i ? AW'(col_i) : offset_i;
  assign sum_o = op_a + op_b;

endmodule

`default_nettype wire

// File: sv/text_console_cursor_scroll_core.sv
// Text console engine top level: sequencer, cursor, screen RAM and output register.
// Depends on tcc_pkg, tcc_ram and tcc_addr_unit.
//
// Usage: requests enter on the s_axis channel (tuser = mode, tdata = character
// and cell address). Each request yields zero to seven results on m_axis; tlast
// marks the final result of a request, tuser gives the result kind (echo byte or
// cell read). Every result carries the cursor after the request. The user must
// load the attribute byte through cfg_we_i/cfg_wdata_i only while idle (not enforced).
//
// Flow: s_axis_tready is high only in the idle state. A plain character goes
// through accept, cell write and emit; a read through accept, RAM read and emit;
// an erase through accept, cell blank and emit of its echo bytes; a newline through
// accept and emit. A scroll adds one pass over the screen RAM through its single
// write port, moving the rows up and blanking the bottom row. A clear is accept and
// one blanking pass, then its echo bytes. After reset the RAM is swept to zero
// with tready low. A stalled receiver holds the output register; the sequencer
// waits on it and the next request is taken only after the last result is loaded.
`default_nettype none

module text_console_cursor_scroll_core #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration: text_attribute
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_wdata_i,
  // requests
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // [7:0] char_code, [18:8] cell_address
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] mode
  // results
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // [7:0] echo_byte, [23:8] cell_value,
                                           // [28:24] cursor_row_out, [35:29] cursor_col_out
  output logic             m_axis_tuser,   // [0] result_kind
  output logic             m_axis_tlast    // last
);
  import tcc_pkg::*;

  localparam int unsigned CELLS = ROWS * COLUMNS;
  localparam int unsigned MOVE  = CELLS - COLUMNS;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned RW    = $clog2(ROWS);
  localparam int unsigned CW    = $clog2(COLUMNS + 1);

  // Request fields
  logic [1:0]  in_mode;
  logic [7:0]  in_char;
  logic [10:0] in_addr;
  assign in_mode = s_axis_tuser;
  assign in_char = s_axis_tdata[7:0];
  assign in_addr = s_axis_tdata[18:8];

  state_e        state_q, state_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic          pend_q, pend_d;
  logic [AW-1:0] wdst_q, wdst_d;
  logic [RW-1:0] row_q, row_d;
  logic [CW-1:0] col_q, col_d;
  logic [7:0]    ch_q, ch_d;
  seq_e          seq_q, seq_d;
  logic          oor_q, oor_d;
  logic [15:0]   cell_q, cell_d;
  seq_idx_t      idx_q, idx_d;
  logic [7:0]    attr_q;

  logic          out_valid_q, out_valid_d;
  logic          out_kind_q, out_kind_d;
  logic [7:0]    out_echo_q, out_echo_d;
  logic [15:0]   out_cell_q, out_cell_d;
  logic [4:0]    out_row_q, out_row_d;
  logic [6:0]    out_col_q, out_col_d;
  logic          out_last_q, out_last_d;

  // RAM and address unit hookup
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [15:0]   ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [15:0]   ram_rdata;
  logic          au_use_cursor;
  logic [AW-1:0] au_sum;

  logic [15:0]   blank;
  logic [RW:0]   row_inc;
  logic          wrap;
  logic [RW:0]   put_row;
  logic          slot_free;

  assign blank     = {attr_q, CH_SPACE};
  assign row_inc   = (RW + 1)'(row_q) + (RW + 1)'(1);
  assign wrap      = (32'(col_q) >= 32'(COLUMNS));
  assign put_row   = wrap ? row_inc : (RW + 1)'(row_q);
  assign slot_free = !out_valid_q || m_axis_tready;

  assign au_use_cursor = (state_q == ST_PUT) || (state_q == ST_ERASE);

  tcc_addr_unit #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_addr (
    .use_cursor_i (au_use_cursor),
    .row_i        (row_q),
    .col_i        (col_q),
    .base_i       (ptr_q),
    .offset_i     (AW'(COLUMNS)),
    .sum_o        (au_sum)
  );

  tcc_ram #(
    .WIDTH (16),
    .DEPTH (CELLS)
  ) u_screen (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // State and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      ptr_q       <= '0;
      pend_q      <= 1'b0;
      row_q       <= '0;
      col_q       <= '0;
      idx_q       <= '0;
      seq_q       <= SEQ_CHAR;
      attr_q      <= 8'h02;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      pend_q      <= pend_d;
      row_q       <= row_d;
      col_q       <= col_d;
      idx_q       <= idx_d;
      seq_q       <= seq_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        attr_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    wdst_q     <= wdst_d;
    ch_q       <= ch_d;
    oor_q      <= oor_d;
    cell_q     <= cell_d;
    out_kind_q <= out_kind_d;
    out_echo_q <= out_echo_d;
    out_cell_q <= out_cell_d;
    out_row_q  <= out_row_d;
    out_col_q  <= out_col_d;
    out_last_q <= out_last_d;
  end

  // Sequencer: next state, RAM control, output loading
  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    pend_d      = 1'b0;
    wdst_d      = wdst_q;
    row_d       = row_q;
    col_d       = col_q;
    ch_d        = ch_q;
    seq_d       = seq_q;
    oor_d       = oor_q;
    cell_d      = cell_q;
    idx_d       = idx_q;
    ram_we      = 1'b0;
    ram_waddr   = ptr_q;
    ram_wdata   = blank;
    ram_raddr   = AW'(in_addr);
    out_valid_d = out_valid_q && !m_axis_tready;
    out_kind_d  = out_kind_q;
    out_echo_d  = out_echo_q;
    out_cell_d  = out_cell_q;
    out_row_d   = out_row_q;
    out_col_d   = out_col_q;
    out_last_d  = out_last_q;
    s_axis_tready = 1'b0;

    case (state_q)
      // Sweep zeros through the RAM after reset
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
        ptr_d     = ptr_q + AW'(1);
        if (ptr_q == AW'(CELLS - 1)) begin
          ptr_d   = '0;
          state_d = ST_IDLE;
        end
      end

      // Take a request and update the cursor
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        idx_d = '0;
        ch_d  = in_char;
        if (s_axis_tvalid) begin
          case (in_mode)
            MODE_PUT: begin
              if (in_char == CH_LF) begin
                seq_d = SEQ_NEWLINE;
                col_d = '0;
                if (32'(row_inc) >= 32'(ROWS)) begin
                  row_d   = RW'(ROWS - 1);
                  ptr_d   = '0;
                  state_d = ST_SCROLL;
                end else begin
                  row_d   = RW'(row_inc);
                  state_d = ST_EMIT;
                end
              end else if (in_char != CH_CR) begin
                seq_d = SEQ_CHAR;
                if (wrap) begin
                  col_d = '0;
                end
                if (32'(put_row) >= 32'(ROWS)) begin
                  row_d   = RW'(ROWS - 1);
                  ptr_d   = '0;
                  state_d = ST_SCROLL;
                end else begin
                  row_d   = RW'(put_row);
                  state_d = ST_PUT;
                end
              end
            end
            MODE_CLEAR: begin
              seq_d   = SEQ_CLEAR;
              row_d   = '0;
              col_d   = '0;
              ptr_d   = '0;
              state_d = ST_CLEAR;
            end
            MODE_ERASE: begin
              seq_d = SEQ_ERASE;
              if (col_q != '0) begin
                col_d   = col_q - CW'(1);
                state_d = ST_ERASE;
              end else if (row_q != '0) begin
                row_d   = row_q - RW'(1);
                col_d   = CW'(COLUMNS - 1);
                state_d = ST_ERASE;
              end
            end
            MODE_READ: begin
              seq_d   = SEQ_READ;
              oor_d   = (32'(in_addr) >= 32'(CELLS));
              state_d = ST_READ;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end

      // Move rows up: read ptr+COLUMNS, write it to ptr in the next cycle
      ST_SCROLL: begin
        ram_raddr = au_sum;
        ram_we    = pend_q;
        ram_waddr = wdst_q;
        ram_wdata = ram_rdata;
        if (ptr_q == AW'(MOVE)) begin
          state_d = ST_BLANK;
        end else begin
          pend_d = 1'b1;
          wdst_d = ptr_q;
          ptr_d  = ptr_q + AW'(1);
        end
      end

      // Blank the bottom row
      ST_BLANK: begin
        ram_we = 1'b1;
        ptr_d  = ptr_q + AW'(1);
        if (ptr_q == AW'(CELLS - 1)) begin
          ptr_d   = '0;
          state_d = (seq_q == SEQ_CHAR) ? ST_PUT : ST_EMIT;
        end
      end

      // Write the character at the cursor and advance
      ST_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = au_sum;
        ram_wdata = {attr_q, ch_q};
        col_d     = col_q + CW'(1);
        state_d   = ST_EMIT;
      end

      // Blank the cell under the backed-up cursor
      ST_ERASE: begin
        ram_we    = 1'b1;
        ram_waddr = au_sum;
        state_d   = ST_EMIT;
      end

      // Blank every cell
      ST_CLEAR: begin
        ram_we = 1'b1;
        ptr_d  = ptr_q + AW'(1);
        if (ptr_q == AW'(CELLS - 1)) begin
          ptr_d   = '0;
          state_d = ST_EMIT;
        end
      end

      // Capture read data; out of range reads as zero
      ST_READ: begin
        cell_d  = oor_q ? 16'h0000 : ram_rdata;
        state_d = ST_EMIT;
      end

      // Hand results to the output register one by one
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = (seq_q == SEQ_READ);
          out_echo_d  = seq_byte(seq_q, idx_q, ch_q);
          out_cell_d  = (seq_q == SEQ_READ) ? cell_q : 16'h0000;
          out_row_d   = 5'(row_q);
          out_col_d   = 7'(col_q);
          out_last_d  = (idx_q == seq_last(seq_q));
          idx_d       = idx_q + seq_idx_t'(1);
          if (idx_q == seq_last(seq_q)) begin
            state_d = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Result channel
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {4'b0000, out_col_q, out_row_q, out_cell_q, out_echo_q};

endmodule

`default_nettype wire

// File: tb/sv/tb_text_console_cursor_scroll_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for text_console_cursor_scroll_core: drives console requests
// and attribute writes, predicts echo bytes and cell reads with a screen mirror.
// Depends on tcc_pkg and the core RTL.

module tb_text_console_cursor_scroll_core;
  import tcc_pkg::*;

  localparam int unsigned COLUMNS       = 80;
  localparam int unsigned ROWS          = 25;
  localparam int unsigned CELLS         = COLUMNS * ROWS;
  localparam int unsigned PHASES        = 4;
  localparam int unsigned PHASE_ITEMS   = 6;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned STALL_LIMIT   = 20000;
  localparam int unsigned SHOWN_ERRORS  = 10;

  // One output beat as seen on the master side
  typedef struct packed {
    logic        kind;
    logic [7:0]  echo_byte;
    logic [15:0] cell_value;
    logic [4:0]  row;
    logic [6:0]  col;
    logic        last;
  } console_out_t;

  // Mirror of the screen, cursor and attribute; queues the outputs each request causes
  class console_mirror;
    logic [15:0]  cells [CELLS];
    int unsigned  row;
    int unsigned  col;
    logic [7:0]   attr;
    console_out_t awaited[$];
    int unsigned  failures;

    function new();
      foreach (cells[i]) cells[i] = '0;
      row      = 0;
      col      = 0;
      attr     = 8'h02;
      failures = 0;
    endfunction

    // Shift every row up by one and blank the bottom row
    function void scroll_up();
      for (int unsigned i = 0; i < CELLS - COLUMNS; i++) cells[i] = cells[i + COLUMNS];
      for (int unsigned i = CELLS - COLUMNS; i < CELLS; i++) cells[i] = {attr, CH_SPACE};
      row = ROWS - 1;
    endfunction

    function int unsigned apply_request(logic [1:0] mode, logic [7:0] ch, logic [10:0] addr);
      logic [7:0]   echoes[$];
      logic         is_read;
      logic [15:0]  read_value;
      console_out_t beat;
      is_read    = 1'b0;
      read_value = '0;
      case (mode)
        MODE_PUT: begin
          if (ch == CH_LF) begin
            col = 0;
            row++;
            if (row >= ROWS) scroll_up();
            echoes.push_back(CH_CR);
            echoes.push_back(CH_LF);
          end else if (ch != CH_CR) begin
            // resolve a pending wrap before writing
            if (col >= COLUMNS) begin
              col = 0;
              row++;
            end
            if (row >= ROWS) scroll_up();
            cells[row * COLUMNS + col] = {attr, ch};
            col++;
            echoes.push_back(ch);
          end
        end
        MODE_CLEAR: begin
          foreach (cells[i]) cells[i] = {attr, CH_SPACE};
          row = 0;
          col = 0;
          for (int unsigned i = 0; i < CLEAR_LEN; i++) echoes.push_back(CLEAR_SEQ[i]);
        end
        MODE_ERASE: begin
          // back up one cell, across rows; nothing happens at the origin
          if (col > 0 || row > 0) begin
            if (col > 0) begin
              col--;
            end else begin
              row--;
              col = COLUMNS - 1;
            end
            cells[row * COLUMNS + col] = {attr, CH_SPACE};
            echoes.push_back(CH_BS);
            echoes.push_back(CH_SPACE);
            echoes.push_back(CH_BS);
          end
        end
        MODE_READ: begin
          is_read    = 1'b1;
          read_value = (addr < CELLS) ? cells[addr] : 16'h0000;
        end
        default: begin
        end
      endcase

      // every beat carries the cursor after the whole step
      beat.row = 5'(row);
      beat.col = 7'(col);
      if (is_read) begin
        beat.kind       = 1'b1;
        beat.echo_byte  = '0;
        beat.cell_value = read_value;
        beat.last       = 1'b1;
        awaited.push_back(beat);
        return 1;
      end
      foreach (echoes[k]) begin
        beat.kind       = 1'b0;
        beat.echo_byte  = echoes[k];
        beat.cell_value = '0;
        beat.last       = (k == echoes.size() - 1);
        awaited.push_back(beat);
      end
      return echoes.size();
    endfunction

    function string describe(console_out_t r);
      return $sformatf("kind=%0d echo=%02h cell=%04h row=%0d col=%0d last=%0d",
                       r.kind, r.echo_byte, r.cell_value, r.row, r.col, r.last);
    endfunction

    function void note_failure(string what);
      failures++;
      if (failures <= SHOWN_ERRORS) $display("%0t: %s", $time, what);
    endfunction

    function void check_output(console_out_t got);
      console_out_t want;
      if (awaited.size() == 0) begin
        note_failure({"output with nothing awaited: ", describe(got)});
        return;
      end
      want = awaited.pop_front();
      if (got.kind !== want.kind || got.echo_byte !== want.echo_byte ||
          got.cell_value !== want.cell_value || got.row !== want.row ||
          got.col !== want.col || got.last !== want.last)
        note_failure($sformatf("mismatch: expected %s, got %s", describe(want), describe(got)));
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [7:0]  cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;  // [7:0] char_code, [18:8] cell_address
  logic [1:0]  s_axis_tuser  = '0;  // [1:0] mode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // [7:0] echo, [23:8] cell, [28:24] row, [35:29] col
  logic        m_axis_tuser;        // [0] result_kind
  logic        m_axis_tlast;

  console_mirror mirror = new();
  int unsigned   src_idle_pct      = 0;
  int unsigned   sink_idle_pct     = 0;
  int unsigned   answered_requests = 0;
  bit            sink_hold_req     = 1'b0;

  always #5 clk_i = ~clk_i;

  text_console_cursor_scroll_core #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  // Mostly short gaps, now and then a long one
  function automatic int unsigned gap_length();
    if ($urandom_range(9) == 0) return $urandom_range(60, 20);
    return $urandom_range(3, 1);
  endfunction

  function automatic logic [10:0] any_addr();
    return 11'($urandom_range(2047));
  endfunction

  // Any byte except newline and carriage return, so each one lands in a cell
  function automatic logic [7:0] line_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (c == CH_LF || c == CH_CR);
    return c;
  endfunction

  // Offer one request and hold it until the core takes it
  task automatic send_request(input logic [1:0] mode, input logic [7:0] ch,
                              input logic [10:0] addr);
    int unsigned gap;
    bit          taken;
    gap = ($urandom_range(99) < src_idle_pct) ? gap_length() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {5'b0, addr, ch};
    do begin
      @(negedge clk_i);
      taken = s_axis_tready;
      @(posedge clk_i);
    end while (!taken);
    if (mirror.apply_request(mode, ch, addr) > 0) answered_requests++;
  endtask

  // Stop offering and wait until the core has delivered everything and is idle
  task automatic drain_requests();
    s_axis_tvalid <= 1'b0;
    while (mirror.awaited.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
  endtask

  task automatic write_attribute(input logic [7:0] value);
    drain_requests();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    mirror.attr = value;
  endtask

  // Result side: random stalls, a long hold-off on request, check every accepted beat
  initial begin
    int unsigned  stall_left;
    console_out_t got;
    stall_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        stall_left    = HOLD_CYCLES;
      end else if (stall_left == 0 && $urandom_range(99) < sink_idle_pct) begin
        stall_left = gap_length();
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
      @(negedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind       = m_axis_tuser;
        got.echo_byte  = m_axis_tdata[7:0];
        got.cell_value = m_axis_tdata[23:8];
        got.row        = m_axis_tdata[28:24];
        got.col        = m_axis_tdata[35:29];
        got.last       = m_axis_tlast;
        mirror.check_output(got);
      end
    end
  end

  // Watchdog: end the run when nothing moves on either side for too long
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    @(posedge rst_ni);
    while (quiet_cycles < STALL_LIMIT) begin
      @(negedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("FAIL text_console_cursor_scroll_core");
    $finish;
  end

  // Stimulus
  initial begin
    int unsigned pick;
    int unsigned burst;
    int unsigned phase;
    int unsigned phase_end;
    int unsigned sel;
    bit          long_done;
    long_done     = 1'b0;
    src_idle_pct  = 30;
    sink_idle_pct = 30;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    // wait out the clearing sweep
    drain_requests();

    // Directed: reset contents, field extremes, origin cases, wrap pending
    send_request(MODE_READ,  8'h00, 11'd0);
    send_request(MODE_ERASE, 8'hFF, 11'h7FF);
    send_request(MODE_PUT,   CH_CR, 11'h000);
    send_request(MODE_PUT,   8'h00, 11'h7FF);
    send_request(MODE_PUT,   8'hFF, 11'h000);
    send_request(MODE_READ,  8'h00, 11'd1);
    send_request(MODE_READ,  8'hFF, 11'd2047);
    send_request(MODE_READ,  8'h00, 11'd2000);
    send_request(MODE_READ,  8'hFF, 11'd1999);
    send_request(MODE_PUT,   CH_LF, 11'h3C0);
    // erase across a row boundary, then fill the last column
    send_request(MODE_ERASE, 8'h00, 11'h000);
    send_request(MODE_PUT,   8'h41, 11'h123);
    // erase with a wrap pending, refill, then wrap onto the next row
    send_request(MODE_ERASE, 8'h7E, 11'h456);
    send_request(MODE_PUT,   8'h42, 11'h000);
    send_request(MODE_PUT,   8'h43, 11'h7FF);
    send_request(MODE_READ,  8'h00, 11'd79);
    send_request(MODE_READ,  8'h00, 11'd80);
    write_attribute(8'h00);
    send_request(MODE_CLEAR, 8'h5A, 11'h2A5);
    send_request(MODE_READ,  8'h00, 11'd1999);
    write_attribute(8'hFF);
    send_request(MODE_PUT,   8'h55, 11'h555);
    send_request(MODE_PUT,   8'hAA, 11'h2AA);
    send_request(MODE_ERASE, 8'h00, 11'h000);
    send_request(MODE_READ,  8'h00, 11'd1);

    // Random phases, each under its own attribute and idling mix
    for (phase = 0; phase < PHASES; phase++) begin
      write_attribute(8'($urandom_range(255)));
      case (phase)
        0:       src_idle_pct = 25;
        1:       src_idle_pct = 0;
        2:       src_idle_pct = 40;
        default: src_idle_pct = 15;
      endcase
      sink_idle_pct = src_idle_pct;
      // long receiver hold-off while requests keep coming
      if (phase == 2) sink_hold_req = 1'b1;
      phase_end = answered_requests + PHASE_ITEMS;
      while (answered_requests < phase_end) begin
        pick = $urandom_range(99);
        if (phase == 1 && !long_done) begin
          // run down to the bottom row, then overrun it so a wrap scrolls
          while (mirror.row < ROWS - 1) send_request(MODE_PUT, CH_LF, any_addr());
          burst = COLUMNS - mirror.col + $urandom_range(4, 1);
          repeat (burst) send_request(MODE_PUT, line_char(), any_addr());
          long_done = 1'b1;
        end else if (pick < 35) begin
          // short line ended by a newline
          burst = $urandom_range(6);
          repeat (burst) send_request(MODE_PUT, line_char(), any_addr());
          send_request(MODE_PUT, CH_LF, any_addr());
        end else if (pick < 50) begin
          burst = $urandom_range(5, 2);
          repeat (burst) send_request(MODE_PUT, CH_LF, any_addr());
        end else if (pick < 65) begin
          burst = $urandom_range(4, 1);
          repeat (burst) send_request(MODE_ERASE, 8'($urandom_range(255)), any_addr());
        end else if (pick < 85) begin
          // reads, half of them around the cursor row
          burst = $urandom_range(3, 1);
          repeat (burst) begin
            sel = $urandom_range(3);
            if (sel < 2)
              send_request(MODE_READ, 8'($urandom_range(255)),
                           11'(mirror.row * COLUMNS + $urandom_range(COLUMNS - 1)));
            else if (sel == 2)
              send_request(MODE_READ, 8'($urandom_range(255)), 11'($urandom_range(CELLS - 1)));
            else
              send_request(MODE_READ, 8'($urandom_range(255)), any_addr());
          end
        end else begin
          // noise: any mode, any byte, any address
          send_request(2'($urandom_range(3)), 8'($urandom_range(255)), any_addr());
        end
      end
    end

    drain_requests();
    if (mirror.failures == 0)
      $display("PASS text_console_cursor_scroll_core");
    else
      $display("FAIL text_console_cursor_scroll_core");
    $finish;
  end

endmodule
